[hdl/tfr_pkg.sv]
// Shared types and constants for the text frame receiver.
// No dependencies; imported by every module of the block.
package tfr_pkg;

	localparam logic [7:0] HDR_A = 8'h02;
	localparam logic [7:0] HDR_B = 8'h4D;
	localparam logic [7:0] HDR_C = 8'h6C;

	typedef enum logic [3:0] {
		PH_HUNT = 4'd0,
		PH_H1   = 4'd1,
		PH_H2   = 4'd2,
		PH_H3   = 4'd3,
		PH_DEST = 4'd4,
		PH_SRC  = 4'd5,
		PH_LEN  = 4'd6,
		PH_DATA = 4'd7,
		PH_CLO  = 4'd8,
		PH_CHI  = 4'd9
	} phase_t;

	typedef enum logic {
		KIND_PAYLOAD   = 1'b0,
		KIND_FRAME_END = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] src;
		logic [7:0] dst;
		logic [7:0] len;
		logic       ok;
	} result_t;

endpackage

[hdl/text_frame_receiver.sv]
// Text frame receiver: serial bytes in, payload bytes and frame status out.
// Input channel: in_valid/in_ready carry one rx_byte word per handshake.
// Output channel: out_valid/out_ready carry one result word: result_kind 0
// is a payload byte in payload_data, result_kind 1 closes a frame with the
// addresses, frame_length and sum_ok (checksum match).
// Header, address, length and low checksum words produce no output word.
// Throughput: one word per cycle while the output is not stalled. A result
// appears on the output in the cycle after the word that caused it is
// taken, held in the single result register behind the parser.
// in_ready stays high while the result register is empty or being drained,
// so a stalled output holds one result and stops input until it is taken.
// Reset clears the output valid flag (the held result is not reset) and puts
// the parser into header hunt with all held fields and the checksum at zero.
// Depends on tfr_pkg, tfr_parser and tfr_out_reg.
module text_frame_receiver import tfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] payload_data,
	output logic [7:0] source_addr,
	output logic [7:0] dest_addr,
	output logic [7:0] frame_length,
	output logic       sum_ok
);

	logic    take;
	logic    res_valid;
	result_t res;
	result_t held;

	assign in_ready = !out_valid || out_ready;
	assign take     = in_valid && in_ready;

	tfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx_byte  (rx_byte),
		.res_valid(res_valid),
		.res      (res)
	);

	tfr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.res_valid(res_valid),
		.res      (res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.held     (held)
	);

	assign result_kind  = held.kind;
	assign payload_data = held.data;
	assign source_addr  = held.src;
	assign dest_addr    = held.dst;
	assign frame_length = held.len;
	assign sum_ok       = held.ok;

endmodule

[hdl/tfr_parser.sv]
// Frame parser: header hunt, field capture and running checksum.
// Depends on tfr_pkg; produces at most one result per accepted word.
module tfr_parser import tfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  dest_q, dest_d;
	logic [7:0]  src_q, src_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  clo_q, clo_d;
	logic [15:0] sum_add;
	logic [7:0]  count_inc;

	// (b ^ 0xFF) + (b << 8) has no carry between bytes
	assign sum_add   = sum_q + {rx_byte, ~rx_byte};
	assign count_inc = count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			dest_q  <= '0;
			src_q   <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
			clo_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			dest_q  <= dest_d;
			src_q   <= src_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			clo_q   <= clo_d;
		end
	end

	always_comb begin
		phase_d   = PH_HUNT;
		dest_d    = dest_q;
		src_d     = src_q;
		len_d     = len_q;
		count_d   = count_q;
		sum_d     = sum_q;
		clo_d     = clo_q;
		res_valid = 1'b0;
		res.kind  = KIND_PAYLOAD;
		res.data  = '0;
		res.src   = src_q;
		res.dst   = dest_q;
		res.len   = len_q;
		res.ok    = 1'b0;
		unique case (phase_q)
			PH_H1: begin
				if (rx_byte == HDR_B)      phase_d = PH_H2;
				else if (rx_byte == HDR_A) phase_d = PH_H1;
			end
			PH_H2: begin
				if (rx_byte == HDR_C)      phase_d = PH_H3;
				else if (rx_byte == HDR_A) phase_d = PH_H1;
			end
			PH_H3: begin
				if (rx_byte == HDR_A) begin
					phase_d = PH_DEST;
					sum_d   = '0;
				end
			end
			PH_DEST: begin
				dest_d  = rx_byte;
				sum_d   = sum_add;
				phase_d = PH_SRC;
			end
			PH_SRC: begin
				src_d   = rx_byte;
				sum_d   = sum_add;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx_byte;
				count_d = '0;
				sum_d   = sum_add;
				phase_d = (rx_byte == 8'd0) ? PH_CLO : PH_DATA;
			end
			PH_DATA: begin
				sum_d     = sum_add;
				count_d   = count_inc;
				res_valid = 1'b1;
				res.data  = rx_byte;
				phase_d   = (count_inc == len_q) ? PH_CLO : PH_DATA;
			end
			PH_CLO: begin
				clo_d   = rx_byte;
				phase_d = PH_CHI;
			end
			PH_CHI: begin
				res_valid = 1'b1;
				res.kind  = KIND_FRAME_END;
				res.ok    = ({rx_byte, clo_q} == sum_q);
			end
			default: begin
				// hunting, and codes with no meaning
				phase_d = (rx_byte == HDR_A) ? PH_H1 : PH_HUNT;
			end
		endcase
	end

endmodule

[hdl/tfr_out_reg.sv]
// Result register between the parser and the output channel.
// Depends on tfr_pkg; loads on each accepted word, drains on out_ready.
module tfr_out_reg import tfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    res_valid,
	input  result_t res,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t held
);

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign held      = res_q;

endmodule
